[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/rbst_pkg.sv]
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared widths, register indexes and item types of the ray box slab test.
// ----------------------------------------------------------------------------
`default_nettype none
package rbst_pkg;

    localparam int Q_W     = 32;
    localparam int DIFF_W  = Q_W + 1;
    localparam int FRAC_W  = 16;
    localparam int DIV_N   = DIFF_W + FRAC_W;
    localparam int REM_W   = Q_W + 1;
    localparam int NAXES   = 3;
    localparam int CIDX_W  = 3;
    localparam int FIFO_AW = 2;

    localparam logic [CIDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [CIDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [CIDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [CIDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [CIDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CIDX_W-1:0] REG_MAX_Z = 3'd5;

    localparam logic signed [Q_W-1:0] T_NEAR_START = '0;
    localparam logic signed [Q_W-1:0] T_FAR_START  = {1'b0, {(Q_W-1){1'b1}}};

    typedef struct packed {
        logic signed [Q_W-1:0] lo;
        logic signed [Q_W-1:0] hi;
    } bounds_t;

    typedef bounds_t [NAXES-1:0] box_t;

    typedef struct packed {
        logic              par;
        logic              outside;
        logic              neg_lo;
        logic              neg_hi;
        logic [DIFF_W-1:0] num_lo;
        logic [DIFF_W-1:0] num_hi;
        logic [Q_W-1:0]    den;
    } axis_t;

    typedef axis_t [NAXES-1:0] job_t;

endpackage
`default_nettype wire

[rtl/ray_box_slab_test.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray against axis-aligned box test by the slab method in signed Q16.16.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// s_       in         origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
// m_       out        hit, t_near, t_far
// cfg_     in         box register index and value
//
// One ray is accepted every cycle while the output is not stalled; the
// dividers are 49-stage pipelined, one quotient bit a stage.
// Reset is synchronous and active low and clears the box registers.
// A stalled output holds the back; the front queue absorbs the front.
// ----------------------------------------------------------------------------
`default_nettype none
module ray_box_slab_test (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // hit, t_near, t_far, zero padding
    output logic [71:0]       m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [rbst_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [rbst_pkg::Q_W-1:0]    cfg_data
);

    rbst_pkg::box_t box_reg;
    rbst_pkg::job_t f_job;
    rbst_pkg::job_t q_job;
    logic           f_valid, f_ready, q_valid, q_ready;
    logic           hit;
    logic [rbst_pkg::Q_W-1:0] near, far;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                rbst_pkg::REG_MIN_X: box_reg[0].lo <= cfg_data;
                rbst_pkg::REG_MIN_Y: box_reg[1].lo <= cfg_data;
                rbst_pkg::REG_MIN_Z: box_reg[2].lo <= cfg_data;
                rbst_pkg::REG_MAX_X: box_reg[0].hi <= cfg_data;
                rbst_pkg::REG_MAX_Y: box_reg[1].hi <= cfg_data;
                rbst_pkg::REG_MAX_Z: box_reg[2].hi <= cfg_data;
                default: ;
            endcase
        end
    end

    rbst_front u_front (
        .aclk (aclk), .aresetn (aresetn), .box (box_reg),
        .in_valid (s_tvalid), .in_ready (s_tready), .in_data (s_tdata),
        .out_valid (f_valid), .out_ready (f_ready), .out_job (f_job)
    );

    rbst_fifo u_fifo (
        .aclk (aclk), .aresetn (aresetn),
        .in_valid (f_valid), .in_ready (f_ready), .in_job (f_job),
        .out_valid (q_valid), .out_ready (q_ready), .out_job (q_job)
    );

    rbst_back u_back (
        .aclk (aclk), .aresetn (aresetn),
        .in_valid (q_valid), .in_ready (q_ready), .in_job (q_job),
        .out_valid (m_tvalid), .out_ready (m_tready),
        .out_hit (hit), .out_near (near), .out_far (far)
    );

    assign m_tdata = {7'd0, far, near, hit};

endmodule
`default_nettype wire

[rtl/rbst_front.sv]
// ----------------------------------------------------------------------------
// rbst_front
// Accepts rays, classifies each axis as parallel or not and forms the
// magnitudes and signs of the slab divisions.
// ----------------------------------------------------------------------------
`default_nettype none
module rbst_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire rbst_pkg::box_t      box,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [rbst_pkg::Q_W*6-1:0] in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rbst_pkg::job_t           out_job
);

    logic           valid_reg;
    rbst_pkg::job_t job_reg;
    rbst_pkg::job_t job_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_job   = job_reg;

    always_comb begin
        logic signed [rbst_pkg::Q_W-1:0]    org;
        logic signed [rbst_pkg::Q_W-1:0]    dir;
        logic signed [rbst_pkg::DIFF_W-1:0] dlo;
        logic signed [rbst_pkg::DIFF_W-1:0] dhi;
        logic signed [rbst_pkg::DIFF_W-1:0] dsx;
        job_next = '0;
        for (int a = 0; a < rbst_pkg::NAXES; a++) begin
            org = in_data[a*rbst_pkg::Q_W +: rbst_pkg::Q_W];
            dir = in_data[(a+3)*rbst_pkg::Q_W +: rbst_pkg::Q_W];
            dsx = {dir[rbst_pkg::Q_W-1], dir};
            dlo = {box[a].lo[rbst_pkg::Q_W-1], box[a].lo} - {org[rbst_pkg::Q_W-1], org};
            dhi = {box[a].hi[rbst_pkg::Q_W-1], box[a].hi} - {org[rbst_pkg::Q_W-1], org};
            job_next[a].par     = (dir == '0);
            job_next[a].outside = (org < box[a].lo) || (org > box[a].hi);
            job_next[a].neg_lo  = dlo[rbst_pkg::DIFF_W-1] ^ dir[rbst_pkg::Q_W-1];
            job_next[a].neg_hi  = dhi[rbst_pkg::DIFF_W-1] ^ dir[rbst_pkg::Q_W-1];
            job_next[a].num_lo  = dlo[rbst_pkg::DIFF_W-1] ? -dlo : dlo;
            job_next[a].num_hi  = dhi[rbst_pkg::DIFF_W-1] ? -dhi : dhi;
            dsx = dir[rbst_pkg::Q_W-1] ? -dsx : dsx;
            job_next[a].den     = dsx[rbst_pkg::Q_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            job_reg <= job_next;
        end
    end

endmodule
`default_nettype wire

[rtl/rbst_fifo.sv]
// ----------------------------------------------------------------------------
// rbst_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module rbst_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rbst_pkg::job_t in_job,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rbst_pkg::job_t      out_job
);

    localparam int DEPTH = 1 << rbst_pkg::FIFO_AW;

    rbst_pkg::job_t                 mem [DEPTH];
    logic [rbst_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [rbst_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [rbst_pkg::FIFO_AW:0]     count_reg;
    logic                           push;
    logic                           pop;

    assign in_ready  = !count_reg[rbst_pkg::FIFO_AW];
    assign out_valid = (count_reg != '0);
    assign out_job   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_job;
        end
    end

endmodule
`default_nettype wire

[rtl/rbst_div.sv]
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined restoring divider for unsigned magnitudes, one quotient bit per
// stage. The numerator is scaled by the Q16.16 fraction width.
// ----------------------------------------------------------------------------
`default_nettype none
module rbst_div (
    input  wire logic                        aclk,
    input  wire logic                        ce,
    input  wire logic [rbst_pkg::DIFF_W-1:0] num,
    input  wire logic [rbst_pkg::Q_W-1:0]    den,
    output logic      [rbst_pkg::DIV_N-1:0]  quo
);

    localparam int N  = rbst_pkg::DIV_N;
    localparam int QW = rbst_pkg::Q_W;

    function automatic logic [QW+N-1:0] div_step(input logic [QW-1:0] rem,
            input logic nb, input logic [QW-1:0] d, input logic [N-1:0] q);
        logic [rbst_pkg::REM_W-1:0] trial;
        logic [rbst_pkg::REM_W-1:0] diff;
        trial = {rem, nb};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            div_step = {diff[QW-1:0], q[N-2:0], 1'b1};
        end else begin
            div_step = {trial[QW-1:0], q[N-2:0], 1'b0};
        end
    endfunction

    logic [QW-1:0]   rem_reg [1:N];
    logic [N-1:0]    dvd_reg [1:N];
    logic [QW-1:0]   den_reg [1:N];
    logic [N-1:0]    quo_reg [1:N];
    logic [QW-1:0]   rem_next [N];
    logic [N-1:0]    quo_next [N];

    always_comb begin
        {rem_next[0], quo_next[0]} = div_step('0, num[rbst_pkg::DIFF_W-1], den, '0);
        for (int k = 1; k < N; k++) begin
            {rem_next[k], quo_next[k]} = div_step(rem_reg[k], dvd_reg[k][N-1],
                                                  den_reg[k], quo_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[1] <= rem_next[0];
            dvd_reg[1] <= {num[rbst_pkg::DIFF_W-2:0], {rbst_pkg::FRAC_W{1'b0}}, 1'b0};
            den_reg[1] <= den;
            quo_reg[1] <= quo_next[0];
            for (int k = 1; k < N; k++) begin
                rem_reg[k+1] <= rem_next[k];
                dvd_reg[k+1] <= {dvd_reg[k][N-2:0], 1'b0};
                den_reg[k+1] <= den_reg[k];
                quo_reg[k+1] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[N];

endmodule
`default_nettype wire

[rtl/rbst_back.sv]
// ----------------------------------------------------------------------------
// rbst_back
// Divides, saturates, orders and folds the slab distances of each item and
// holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module rbst_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rbst_pkg::job_t in_job,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic                out_hit,
    output logic [rbst_pkg::Q_W-1:0] out_near,
    output logic [rbst_pkg::Q_W-1:0] out_far
);

    localparam int N  = rbst_pkg::DIV_N;
    localparam int NA = rbst_pkg::NAXES;
    localparam int QW = rbst_pkg::Q_W;

    typedef struct packed {
        logic par;
        logic outside;
        logic neg_lo;
        logic neg_hi;
    } side_t;

    typedef struct packed {
        logic par;
        logic outside;
        logic signed [QW-1:0] t1;
        logic signed [QW-1:0] t2;
    } dist_t;

    typedef struct packed {
        logic hit;
        logic signed [QW-1:0] near;
        logic signed [QW-1:0] far;
    } run_t;

    function automatic logic signed [QW-1:0] sat_q(input logic [N-1:0] q, input logic neg);
        logic [QW:0] negq;
        negq = -q[QW:0];
        if (!neg) begin
            sat_q = (q > N'(rbst_pkg::T_FAR_START)) ? rbst_pkg::T_FAR_START : q[QW-1:0];
        end else begin
            sat_q = (q > (N'(1) << (QW-1))) ? {1'b1, {(QW-1){1'b0}}} : negq[QW-1:0];
        end
    endfunction

    logic                    ce;
    logic [N-1:0]            vld_reg;
    side_t [NA-1:0]          side_reg [N];
    logic [N-1:0]            q_lo [NA];
    logic [N-1:0]            q_hi [NA];
    logic                    sv_reg;
    dist_t [NA-1:0]          dist_reg;
    logic [NA-1:0]           fv_reg;
    run_t                    run_reg [NA];
    dist_t [NA-1:0]          fd_reg [NA-1];
    run_t                    run_next [NA];
    logic                    ov_reg;
    run_t                    out_reg;

    assign ce        = !ov_reg || out_ready;
    assign in_ready  = ce;
    assign out_valid = ov_reg;
    assign out_hit   = out_reg.hit;
    assign out_near  = out_reg.near;
    assign out_far   = out_reg.far;

    for (genvar a = 0; a < NA; a++) begin : g_axis
        rbst_div u_div_lo (
            .aclk (aclk), .ce (ce), .num (in_job[a].num_lo), .den (in_job[a].den),
            .quo  (q_lo[a])
        );
        rbst_div u_div_hi (
            .aclk (aclk), .ce (ce), .num (in_job[a].num_hi), .den (in_job[a].den),
            .quo  (q_hi[a])
        );
    end

    always_comb begin
        run_t  prev;
        dist_t d;
        logic signed [QW-1:0] lo;
        logic signed [QW-1:0] hi;
        for (int a = 0; a < NA; a++) begin
            if (a == 0) begin
                prev = '{hit: 1'b1, near: rbst_pkg::T_NEAR_START,
                         far: rbst_pkg::T_FAR_START};
                d    = dist_reg[0];
            end else begin
                prev = run_reg[a-1];
                d    = fd_reg[a-1][a];
            end
            lo = (d.t1 > d.t2) ? d.t2 : d.t1;
            hi = (d.t1 > d.t2) ? d.t1 : d.t2;
            run_next[a] = prev;
            if (prev.hit) begin
                if (d.par) begin
                    run_next[a].hit = !d.outside;
                end else begin
                    if (lo > prev.near) begin
                        run_next[a].near = lo;
                    end
                    if (hi < prev.far) begin
                        run_next[a].far = hi;
                    end
                    run_next[a].hit = !(((lo > prev.near) ? lo : prev.near) >
                                        ((hi < prev.far) ? hi : prev.far));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            sv_reg  <= 1'b0;
            fv_reg  <= '0;
            ov_reg  <= 1'b0;
        end else if (ce) begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
            sv_reg  <= vld_reg[N-1];
            fv_reg  <= {fv_reg[NA-2:0], sv_reg};
            ov_reg  <= fv_reg[NA-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int a = 0; a < NA; a++) begin
                side_reg[0][a] <= '{par: in_job[a].par, outside: in_job[a].outside,
                                    neg_lo: in_job[a].neg_lo, neg_hi: in_job[a].neg_hi};
            end
            for (int k = 1; k < N; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int a = 0; a < NA; a++) begin
                dist_reg[a].par     <= side_reg[N-1][a].par;
                dist_reg[a].outside <= side_reg[N-1][a].outside;
                dist_reg[a].t1      <= sat_q(q_lo[a], side_reg[N-1][a].neg_lo);
                dist_reg[a].t2      <= sat_q(q_hi[a], side_reg[N-1][a].neg_hi);
            end
            fd_reg[0] <= dist_reg;
            for (int a = 1; a < NA - 1; a++) begin
                fd_reg[a] <= fd_reg[a-1];
            end
            for (int a = 0; a < NA; a++) begin
                run_reg[a] <= run_next[a];
            end
            out_reg <= run_reg[NA-1];
        end
    end

endmodule
`default_nettype wire

[rtl/rbst_checker.sv]
// ----------------------------------------------------------------------------
// rbst_checker
// Port-level checks of the ray box slab test, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rbst_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata
);

    logic signed [31:0] near;
    logic signed [31:0] far;

    assign near = m_tdata[32:1];
    assign far  = m_tdata[64:33];

    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_SAME(a_near_pos, aclk, aresetn, m_tvalid, near >= 0)
    `ASSERT_SAME(a_hit_order, aclk, aresetn, m_tvalid && m_tdata[0], near <= far)
    `ASSERT_SAME(a_pad, aclk, aresetn, m_tvalid, m_tdata[71:65] == 7'd0)

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
    .aclk (aclk), .aresetn (aresetn), .m_tvalid (m_tvalid),
    .m_tready (m_tready), .m_tdata (m_tdata)
);
`default_nettype wire
